>>> hdl/assert_macros.svh
// Assertion macros used by the checker of the LCD nibble sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies another one on the following edge.
`define CLNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/clns_pkg.sv
// Package with types, constants and tables of the LCD nibble sequencer.
`default_nettype none

package clns_pkg;

  localparam int unsigned LineCharsDef = 16;
  localparam int unsigned GreetLen     = 7;

  localparam logic [4:0] SettleShort = 5'd10;
  localparam logic [4:0] SettleLong  = 5'd30;

  localparam logic [3:0] RomInitStart = 4'd0;
  localparam logic [3:0] RomLineStart = 4'd12;
  localparam logic [3:0] RomInitEnd   = 4'd14;
  localparam logic [3:0] RomLast      = 4'd15;

  typedef enum logic [1:0] {
    ACT_INIT = 2'd0,
    ACT_LINE = 2'd1,
    ACT_CHAR = 2'd2,
    ACT_READ = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    SRC_ROM     = 2'd0,
    SRC_CHAR_HI = 2'd1,
    SRC_CHAR_LO = 2'd2,
    SRC_REPLY   = 2'd3
  } emit_src_e;

  typedef struct packed {
    logic      accept;
    logic      store;
    logic      line_clr;
    logic      rd;
    logic      rd_col;
    logic      ptr_clr;
    logic      ptr_inc;
    logic      col_inc;
    logic      char_ld;
    logic      emit;
    emit_src_e src;
    logic [3:0] step;
    logic      last;
  } clns_cmd_t;

  typedef struct packed {
    logic out_free;
    logic col_ok;
    logic char_show;
    logic have;
  } clns_sts_t;

  typedef struct packed {
    logic       kind;
    logic       reg_select;
    logic [3:0] nibble;
    logic [4:0] settle_ms;
    logic [7:0] read_char;
    logic       read_valid;
    logic       last;
  } clns_out_t;

  typedef struct packed {
    logic [3:0] nib;
    logic [4:0] settle;
  } rom_entry_t;

  // Wake nibbles, mode bytes, then clear and home.
  function automatic rom_entry_t rom_entry(input logic [3:0] step);
    rom_entry_t e;
    e.settle = SettleShort;
    unique case (step)
      4'd0:  e.nib = 4'h3;
      4'd1:  e.nib = 4'h3;
      4'd2:  e.nib = 4'h3;
      4'd3:  e.nib = 4'h2;
      4'd4:  e.nib = 4'h2;
      4'd5:  e.nib = 4'h0;
      4'd6:  e.nib = 4'h1;
      4'd7:  e.nib = 4'h4;
      4'd8:  e.nib = 4'h0;
      4'd9:  e.nib = 4'hC;
      4'd10: e.nib = 4'h0;
      4'd11: e.nib = 4'h6;
      4'd12: e.nib = 4'h0;
      4'd13: begin
        e.nib    = 4'h1;
        e.settle = SettleLong;
      end
      4'd14: e.nib = 4'h0;
      4'd15: begin
        e.nib    = 4'h2;
        e.settle = SettleLong;
      end
    endcase
    return e;
  endfunction

  function automatic logic [7:0] greet_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h4F;
      3'd1:    c = 8'h6C;
      3'd2:    c = 8'h61;
      3'd3:    c = 8'h20;
      3'd4:    c = 8'h4C;
      3'd5:    c = 8'h43;
      3'd6:    c = 8'h44;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/clns_if.sv
// Input and output channel interfaces of the LCD nibble sequencer.
`default_nettype none

interface clns_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] char_code;

  modport source (output valid, output action, output char_code, input ready);
  modport sink (input valid, input action, input char_code, output ready);
endinterface

interface clns_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       reg_select;
  logic [3:0] nibble;
  logic [4:0] settle_ms;
  logic [7:0] read_char;
  logic       read_valid;
  logic       last;

  modport source (output valid, output kind, output reg_select, output nibble,
                  output settle_ms, output read_char, output read_valid, output last,
                  input ready);
  modport sink (input valid, input kind, input reg_select, input nibble,
                input settle_ms, input read_char, input read_valid, input last,
                output ready);
endinterface

`default_nettype wire

>>> hdl/clns_datapath.sv
// Datapath: text store, line position registers and the output register.
`default_nettype none

module clns_datapath import clns_pkg::*; #(
  parameter int unsigned LINE_CHARS = LineCharsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire clns_cmd_t  cmd_i,
  output clns_sts_t       sts_o,
  input  wire logic [7:0] in_char_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output clns_out_t       out_o
);

  localparam int unsigned CntW   = $clog2(LINE_CHARS + 1);
  localparam int unsigned IdxW   = (LINE_CHARS > 1) ? $clog2(LINE_CHARS) : 1;
  localparam int unsigned GreetN = (LINE_CHARS < GreetLen) ? LINE_CHARS : GreetLen;
  localparam int unsigned GIdxW  = (GreetN > 1) ? $clog2(GreetN) : 1;
  localparam logic [CntW-1:0] LineMax  = CntW'(LINE_CHARS);
  localparam logic [CntW-1:0] GreetMax = CntW'(GreetN);

  logic [7:0]      mem_q [LINE_CHARS];
  logic [7:0]      mem_rd_q;
  logic [GreetN-1:0] written_q;
  logic [CntW-1:0] len_q, col_q, ptr_q, rd_addr_q;
  logic            stopped_q;
  logic [7:0]      char_q;
  logic            use_greet_q;
  logic [7:0]      greet_q;
  logic            out_valid_q;
  clns_out_t       out_q, out_d;

  logic [CntW-1:0] rd_addr;
  logic            greet_hit;
  logic [7:0]      greet_d;
  logic [7:0]      rd_data;
  logic            have;
  rom_entry_t      rom;

  assign rd_addr = cmd_i.rd_col ? col_q : ptr_q;

  always_comb begin
    greet_hit = 1'b0;
    greet_d   = 8'h00;
    if (rd_addr < GreetMax) begin
      greet_hit = !written_q[rd_addr[GIdxW-1:0]];
      greet_d   = greet_char(3'(rd_addr));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem_q[col_q[IdxW-1:0]] <= in_char_i;
    end
    if (cmd_i.rd) begin
      mem_rd_q    <= mem_q[rd_addr[IdxW-1:0]];
      rd_addr_q   <= rd_addr;
      use_greet_q <= greet_hit;
      greet_q     <= greet_d;
    end
    if (cmd_i.accept) begin
      char_q <= in_char_i;
    end else if (cmd_i.char_ld) begin
      char_q <= rd_data;
    end
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= GreetMax;
      col_q       <= '0;
      ptr_q       <= '0;
      stopped_q   <= 1'b0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.line_clr) begin
        len_q     <= '0;
        col_q     <= '0;
        stopped_q <= 1'b0;
      end else if (cmd_i.store) begin
        len_q <= col_q + 1'b1;
        col_q <= col_q + 1'b1;
        if (in_char_i == 8'h00) begin
          stopped_q <= 1'b1;
        end
        if (col_q < GreetMax) begin
          written_q[col_q[GIdxW-1:0]] <= 1'b1;
        end
      end else if (cmd_i.col_inc) begin
        col_q <= col_q + 1'b1;
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign rd_data = use_greet_q ? greet_q : mem_rd_q;
  assign have    = (rd_addr_q < len_q) && (rd_addr_q < LineMax) && (rd_data != 8'h00);

  assign sts_o.out_free  = !out_valid_q || out_ready_i;
  assign sts_o.col_ok    = col_q < LineMax;
  assign sts_o.char_show = (in_char_i != 8'h00) && !stopped_q;
  assign sts_o.have      = have;

  assign rom = rom_entry(cmd_i.step);

  always_comb begin
    out_d      = '0;
    out_d.last = cmd_i.last;
    unique case (cmd_i.src)
      SRC_ROM: begin
        out_d.nibble    = rom.nib;
        out_d.settle_ms = rom.settle;
      end
      SRC_CHAR_HI: begin
        out_d.reg_select = 1'b1;
        out_d.nibble     = char_q[7:4];
        out_d.settle_ms  = SettleShort;
      end
      SRC_CHAR_LO: begin
        out_d.reg_select = 1'b1;
        out_d.nibble     = char_q[3:0];
        out_d.settle_ms  = SettleShort;
      end
      SRC_REPLY: begin
        out_d.kind       = 1'b1;
        out_d.read_char  = have ? rd_data : 8'h00;
        out_d.read_valid = have;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

`default_nettype wire

>>> hdl/clns_ctrl.sv
// Controller state machine that sequences strobes, store updates and replies.
`default_nettype none

module clns_ctrl import clns_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_action_i,
  output logic            in_ready_o,
  input  wire clns_sts_t  sts_i,
  output clns_cmd_t       cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ROM  = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CHK  = 3'd3;
  localparam logic [2:0] ST_HI   = 3'd4;
  localparam logic [2:0] ST_LO   = 3'd5;

  logic [2:0] state_q, state_d;
  logic [3:0] step_q, step_d;
  action_e    act_q, act_d;
  logic       pend_q, pend_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    step_d     = step_q;
    act_d      = act_q;
    pend_d     = pend_q;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          act_d        = action_e'(in_action_i);
          unique case (action_e'(in_action_i))
            ACT_INIT: begin
              step_d  = RomInitStart;
              state_d = ST_ROM;
            end
            ACT_LINE: begin
              step_d  = RomLineStart;
              state_d = ST_ROM;
            end
            ACT_CHAR: begin
              if (sts_i.col_ok) begin
                cmd_o.store = 1'b1;
                if (sts_i.char_show) begin
                  state_d = ST_HI;
                end
              end
            end
            ACT_READ: begin
              cmd_o.rd     = 1'b1;
              cmd_o.rd_col = 1'b1;
              state_d      = ST_CHK;
            end
          endcase
        end
      end
      ST_ROM: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_ROM;
          cmd_o.step = step_q;
          cmd_o.last = (step_q == RomLast);
          if (act_q == ACT_INIT && step_q == RomInitEnd) begin
            cmd_o.ptr_clr = 1'b1;
            pend_d        = 1'b0;
            state_d       = ST_RD;
          end else if (step_q == RomLast) begin
            cmd_o.line_clr = 1'b1;
            state_d        = ST_IDLE;
          end else begin
            step_d = step_q + 4'd1;
          end
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_CHK;
      end
      ST_CHK: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (act_q == ACT_READ) begin
            cmd_o.src     = SRC_REPLY;
            cmd_o.last    = 1'b1;
            cmd_o.col_inc = sts_i.have;
            state_d       = ST_IDLE;
          end else begin
            cmd_o.src  = pend_q ? SRC_CHAR_LO : SRC_ROM;
            cmd_o.step = RomLast;
            cmd_o.last = !sts_i.have;
            if (sts_i.have) begin
              cmd_o.char_ld = 1'b1;
              cmd_o.ptr_inc = 1'b1;
              state_d       = ST_HI;
            end else begin
              state_d = ST_IDLE;
            end
          end
        end
      end
      ST_HI: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_CHAR_HI;
          if (act_q == ACT_INIT) begin
            pend_d  = 1'b1;
            state_d = ST_RD;
          end else begin
            state_d = ST_LO;
          end
        end
      end
      ST_LO: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = SRC_CHAR_LO;
          cmd_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= RomInitStart;
      act_q   <= ACT_INIT;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      act_q   <= act_d;
      pend_q  <= pend_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/char_lcd_nibble_sequencer.sv
// Top level: character LCD nibble sequencer with a one-line text store.
// One transaction at a time; the next can be taken as soon as its last result is registered.
// Initialize: fixed strobes, then per stored character a read, a check and its high nibble,
// then a last read and check; each check emits the last home nibble or the prior low nibble.
// Begin-line: clear and home strobes; character: both nibbles if shown; read: one reply.
// Reset: store shows the greeting, length 7, position 0, display running, no output.
`default_nettype none

module char_lcd_nibble_sequencer import clns_pkg::*; #(
  parameter int unsigned LINE_CHARS = LineCharsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  clns_in_if.sink   in_i,
  clns_out_if.source out_o
);

  clns_cmd_t cmd;
  clns_sts_t sts;
  clns_out_t out_q;
  logic      in_ready;
  logic      out_valid;

  clns_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  clns_datapath #(
    .LINE_CHARS (LINE_CHARS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_char_i   (in_i.char_code),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_o       (out_q)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.kind       = out_q.kind;
  assign out_o.reg_select = out_q.reg_select;
  assign out_o.nibble     = out_q.nibble;
  assign out_o.settle_ms  = out_q.settle_ms;
  assign out_o.read_char  = out_q.read_char;
  assign out_o.read_valid = out_q.read_valid;
  assign out_o.last       = out_q.last;

endmodule

`default_nettype wire

>>> hdl/clns_checker.sv
// Port-level checker for the LCD nibble sequencer and its bind statement.
`default_nettype none
`include "assert_macros.svh"

module clns_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_kind_i,
  input wire logic       out_reg_select_i,
  input wire logic [3:0] out_nibble_i,
  input wire logic [4:0] out_settle_ms_i,
  input wire logic [7:0] out_read_char_i,
  input wire logic       out_read_valid_i,
  input wire logic       out_last_i
);

  `CLNS_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_kind_i) && $stable(out_nibble_i) && $stable(out_read_char_i) && $stable(out_last_i), "stalled result changed")
  `CLNS_ASSERT(a_busy_mid_item, (out_valid_i && !out_last_i) |-> !in_ready_i, "new transaction taken before last result")
  `CLNS_ASSERT(a_reply_last, (out_valid_i && out_kind_i) |-> (out_last_i && out_settle_ms_i == 5'd0 && out_nibble_i == 4'd0 && !out_reg_select_i), "read reply malformed")
  `CLNS_ASSERT(a_strobe_fields, (out_valid_i && !out_kind_i) |-> (!out_read_valid_i && out_read_char_i == 8'd0 && (out_settle_ms_i == 5'd10 || out_settle_ms_i == 5'd30)), "strobe malformed")

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_kind_i       (out_o.kind),
  .out_reg_select_i (out_o.reg_select),
  .out_nibble_i     (out_o.nibble),
  .out_settle_ms_i  (out_o.settle_ms),
  .out_read_char_i  (out_o.read_char),
  .out_read_valid_i (out_o.read_valid),
  .out_last_i       (out_o.last)
);

`default_nettype wire
